// ===== rtl/core/pcci_pkg.sv =====
package pcci_pkg;

  localparam int DATA_W  = 32;
  localparam int UDATA_W = 31;
  localparam int PROD_W  = 64;
  localparam int ACC_W   = 65;
  localparam int IDX_W   = 3;
  localparam int STEP_W  = 5;

  localparam logic [IDX_W-1:0] REG_SETPOINT   = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_PROP  = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_INTEG = 3'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_DERIV = 3'd3;
  localparam logic [IDX_W-1:0] REG_GAIN_DIV   = 3'd4;
  localparam logic [IDX_W-1:0] REG_INTEG_MAX  = 3'd5;
  localparam logic [IDX_W-1:0] REG_OUTPUT_MAX = 3'd6;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_ERR,
    OP_INTEG,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_DIV_START,
    OP_ACC_LOAD,
    OP_ACC_ADD,
    OP_CLAMP,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_INPUT,
    HOLD_DIV,
    HOLD_OUT
  } hold_t;

  typedef struct packed {
    op_t   op;
    hold_t hold;
    logic  jump;
    step_t target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic go;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic div_busy;
    logic out_full;
  } stat_t;

  function automatic uword_t prog_rom(input step_t step);
    uword_t w;
    w = '{op: OP_NOP, hold: HOLD_NONE, jump: 1'b1, target: step_t'(0)};
    case (step)
      5'd0:  w = '{op: OP_ACCEPT,    hold: HOLD_INPUT, jump: 1'b0, target: step_t'(0)};
      5'd1:  w = '{op: OP_ERR,       hold: HOLD_NONE,  jump: 1'b0, target: step_t'(0)};
      5'd2:  w = '{op: OP_INTEG,     hold: HOLD_NONE,  jump: 1'b0, target: step_t'(0)};
      5'd3:  w = '{op: OP_MUL_P,     hold: HOLD_NONE,  jump: 1'b0, target: step_t'(0)};
      5'd4:  w = '{op: OP_DIV_START, hold: HOLD_NONE,  jump: 1'b0, target: step_t'(0)};
      5'd5:  w = '{op: OP_NOP,       hold: HOLD_DIV,   jump: 1'b0, target: step_t'(0)};
      5'd6:  w = '{op: OP_ACC_LOAD,  hold: HOLD_NONE,  jump: 1'b0, target: step_t'(0)};
      5'd7:  w = '{op: OP_MUL_I,     hold: HOLD_NONE,  jump: 1'b0, target: step_t'(0)};
      5'd8:  w = '{op: OP_DIV_START, hold: HOLD_NONE,  jump: 1'b0, target: step_t'(0)};
      5'd9:  w = '{op: OP_NOP,       hold: HOLD_DIV,   jump: 1'b0, target: step_t'(0)};
      5'd10: w = '{op: OP_ACC_ADD,   hold: HOLD_NONE,  jump: 1'b0, target: step_t'(0)};
      5'd11: w = '{op: OP_MUL_D,     hold: HOLD_NONE,  jump: 1'b0, target: step_t'(0)};
      5'd12: w = '{op: OP_DIV_START, hold: HOLD_NONE,  jump: 1'b0, target: step_t'(0)};
      5'd13: w = '{op: OP_NOP,       hold: HOLD_DIV,   jump: 1'b0, target: step_t'(0)};
      5'd14: w = '{op: OP_ACC_ADD,   hold: HOLD_NONE,  jump: 1'b0, target: step_t'(0)};
      5'd15: w = '{op: OP_CLAMP,     hold: HOLD_NONE,  jump: 1'b0, target: step_t'(0)};
      5'd16: w = '{op: OP_EMIT,      hold: HOLD_OUT,   jump: 1'b1, target: step_t'(0)};
      default: ;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/pcci_if.sv =====
interface pcci_sample_if import pcci_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] measured;

  modport source (output valid, output measured, input ready);
  modport sink (input valid, input measured, output ready);
endinterface

interface pcci_result_if import pcci_pkg::*;;
  logic               valid;
  logic               ready;
  logic [UDATA_W-1:0] control_out;

  modport source (output valid, output control_out, input ready);
  modport sink (input valid, input control_out, output ready);
endinterface

// ===== rtl/core/pcci_seq.sv =====
module pcci_seq import pcci_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctrl
);

  step_t  step;
  step_t  step_next;
  uword_t word;
  logic   hold_now;

  assign word = prog_rom(step);

  always_comb begin
    case (word.hold)
      HOLD_NONE:  hold_now = 1'b0;
      HOLD_INPUT: hold_now = !stat.in_valid;
      HOLD_DIV:   hold_now = stat.div_busy;
      HOLD_OUT:   hold_now = stat.out_full;
      default:    hold_now = 1'b0;
    endcase
  end

  always_comb begin
    if (hold_now) begin
      step_next = step;
    end else if (word.jump) begin
      step_next = word.target;
    end else begin
      step_next = step + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

  assign ctrl.op = word.op;
  assign ctrl.go = !hold_now;

endmodule

// ===== rtl/core/pcci_div.sv =====
module pcci_div import pcci_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [PROD_W-1:0] dividend,
  input  logic [UDATA_W-1:0]       divisor,
  output logic                     busy,
  output logic [PROD_W-1:0]        q_mag,
  output logic                     q_neg
);

  localparam int CNT_W = $clog2(PROD_W / 2);

  logic [CNT_W-1:0]   cnt;
  logic [PROD_W-1:0]  dvd;
  logic [UDATA_W-1:0] rem;
  logic [UDATA_W-1:0] dsr;
  logic [UDATA_W:0]   sh1;
  logic [UDATA_W:0]   sh2;
  logic               ge1;
  logic               ge2;
  logic [UDATA_W-1:0] r1;
  logic [UDATA_W-1:0] r2;

  // Two restoring steps per cycle.
  always_comb begin
    sh1 = {rem, dvd[PROD_W-1]};
    ge1 = sh1 >= {1'b0, dsr};
    r1  = ge1 ? UDATA_W'(sh1 - {1'b0, dsr}) : sh1[UDATA_W-1:0];
    sh2 = {r1, dvd[PROD_W-2]};
    ge2 = sh2 >= {1'b0, dsr};
    r2  = ge2 ? UDATA_W'(sh2 - {1'b0, dsr}) : sh2[UDATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(PROD_W / 2 - 1);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= dividend[PROD_W-1] ? PROD_W'(-dividend) : dividend;
      rem   <= '0;
      q_neg <= dividend[PROD_W-1];
      dsr   <= (divisor == '0) ? UDATA_W'(1) : divisor;
    end else if (busy) begin
      dvd <= {dvd[PROD_W-3:0], ge1, ge2};
      rem <= r2;
    end
  end

  assign q_mag = dvd;

endmodule

// ===== rtl/core/pcci_dp.sv =====
module pcci_dp import pcci_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  ctrl_t                    ctrl,
  input  logic                     cfg_wr_en,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [DATA_W-1:0]        cfg_wr_data,
  input  logic signed [DATA_W-1:0] measured,
  input  logic [PROD_W-1:0]        q_mag,
  input  logic                     q_neg,
  output logic signed [PROD_W-1:0] prod,
  output logic [UDATA_W-1:0]       divisor,
  output logic [UDATA_W-1:0]       cv
);

  logic signed [DATA_W-1:0] setpoint;
  logic signed [DATA_W-1:0] gain_prop;
  logic signed [DATA_W-1:0] gain_integ;
  logic signed [DATA_W-1:0] gain_deriv;
  logic [UDATA_W-1:0]       integ_max;
  logic [UDATA_W-1:0]       out_max;

  logic signed [DATA_W-1:0] meas;
  logic signed [DATA_W-1:0] err;
  logic [UDATA_W-1:0]       integ;
  logic signed [DATA_W-1:0] deriv;
  logic signed [ACC_W-1:0]  acc;

  logic signed [DATA_W-1:0] prev_error;
  logic [UDATA_W-1:0]       prev_integral;
  logic [UDATA_W-1:0]       prev_output;

  logic signed [DATA_W+1:0] integ_sum;
  logic [UDATA_W-1:0]       integ_next;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [ACC_W-1:0]  q_ext;
  logic [UDATA_W-1:0]       cv_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint   <= '0;
      gain_prop  <= '0;
      gain_integ <= '0;
      gain_deriv <= '0;
      divisor    <= UDATA_W'(1);
      integ_max  <= '0;
      out_max    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SETPOINT:   setpoint   <= cfg_wr_data;
        REG_GAIN_PROP:  gain_prop  <= cfg_wr_data;
        REG_GAIN_INTEG: gain_integ <= cfg_wr_data;
        REG_GAIN_DERIV: gain_deriv <= cfg_wr_data;
        REG_GAIN_DIV:   divisor    <= cfg_wr_data[UDATA_W-1:0];
        REG_INTEG_MAX:  integ_max  <= cfg_wr_data[UDATA_W-1:0];
        REG_OUTPUT_MAX: out_max    <= cfg_wr_data[UDATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    integ_sum = $signed({3'b000, prev_integral}) + $signed({{2{err[DATA_W-1]}}, err});
    if (prev_output >= out_max) begin
      integ_next = prev_integral;
    end else if (integ_sum[DATA_W+1]) begin
      integ_next = '0;
    end else if (integ_sum > $signed({3'b000, integ_max})) begin
      integ_next = integ_max;
    end else begin
      integ_next = integ_sum[UDATA_W-1:0];
    end
  end

  always_comb begin
    case (ctrl.op)
      OP_MUL_I: begin
        mul_a = gain_integ;
        mul_b = $signed({1'b0, integ});
      end
      OP_MUL_D: begin
        mul_a = gain_deriv;
        mul_b = deriv;
      end
      default: begin
        mul_a = gain_prop;
        mul_b = err;
      end
    endcase
  end

  assign q_ext = $signed({1'b0, q_mag});

  always_comb begin
    if (acc[ACC_W-1]) begin
      cv_next = '0;
    end else if (acc > $signed({{(ACC_W-UDATA_W){1'b0}}, out_max})) begin
      cv_next = out_max;
    end else begin
      cv_next = acc[UDATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.go) begin
      case (ctrl.op)
        OP_ACCEPT: meas <= measured;
        OP_ERR:    err  <= setpoint - meas;
        OP_INTEG: begin
          integ <= integ_next;
          deriv <= err - prev_error;
        end
        OP_MUL_P, OP_MUL_I, OP_MUL_D: prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        OP_ACC_LOAD: acc <= q_neg ? -q_ext : q_ext;
        OP_ACC_ADD:  acc <= q_neg ? acc - q_ext : acc + q_ext;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error    <= '0;
      prev_integral <= '0;
      prev_output   <= '0;
    end else if (ctrl.go && ctrl.op == OP_CLAMP) begin
      prev_error    <= err;
      prev_integral <= integ;
      prev_output   <= cv_next;
    end
  end

  assign cv = prev_output;

endmodule

// ===== rtl/core/pid_controller_clamped_integral_top.sv =====
// PID controller with anti-windup, run by a microcoded sequencer over a shared datapath.
// One sample is processed at a time: the next sample beat is accepted only once
// the 17-step program, with three passes of the two-bit-per-cycle divider, has
// emitted the previous result. Reset (synchronous, active high) returns the
// program to its first step, loads gain_divisor with one and the other configuration
// registers and the stored error, integral and output with zero.
module pid_controller_clamped_integral_top import pcci_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]  cfg_wr_data,
  pcci_sample_if.sink        sample,
  pcci_result_if.source      result
);

  ctrl_t                    ctrl;
  stat_t                    stat;
  logic signed [PROD_W-1:0] prod;
  logic [UDATA_W-1:0]       divisor;
  logic [UDATA_W-1:0]       cv;
  logic [PROD_W-1:0]        q_mag;
  logic                     q_neg;
  logic                     div_busy;
  logic                     div_start;
  logic                     emit;
  logic                     out_valid;
  logic [UDATA_W-1:0]       out_data;

  assign div_start = ctrl.go && ctrl.op == OP_DIV_START;
  assign emit      = ctrl.go && ctrl.op == OP_EMIT;

  assign stat.in_valid = sample.valid;
  assign stat.div_busy = div_busy;
  assign stat.out_full = out_valid && !result.ready;

  assign sample.ready = !rst && ctrl.op == OP_ACCEPT;

  pcci_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  pcci_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .measured    (sample.measured),
    .q_mag       (q_mag),
    .q_neg       (q_neg),
    .prod        (prod),
    .divisor     (divisor),
    .cv          (cv)
  );

  pcci_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (divisor),
    .busy     (div_busy),
    .q_mag    (q_mag),
    .q_neg    (q_neg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= cv;
    end
  end

  assign result.valid       = out_valid;
  assign result.control_out = out_data;

  a_ready_not_dividing: assert property (@(posedge clk) disable iff (rst)
    sample.ready |-> !div_busy)
    else $error("Sample beat offered while the divider is busy.");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("Divider started while still busy.");

  a_start_sets_busy: assert property (@(posedge clk) disable iff (rst)
    div_start |=> div_busy)
    else $error("Divider did not go busy after a start.");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || result.ready))
    else $error("Result register overwritten before its beat was taken.");

endmodule
